// ===== sv/trle_pkg.sv =====
// Shared types and constants for the Targa run-length pixel decoder.
package trle_pkg;

    // Image size limit: at most 2^PIXEL_COUNT_BITS pixels per image
    localparam int PIXEL_COUNT_BITS = 24;
    localparam int LEFT_W           = PIXEL_COUNT_BITS + 1;
    localparam int CFG_PIX_W        = 25;
    localparam int CMP_W            = (CFG_PIX_W > LEFT_W) ? CFG_PIX_W : LEFT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PIXELS = 2'd2;

    // Packet header decode
    localparam logic [7:0] RUN_FLAG_MIN = 8'd128;
    localparam logic [8:0] RUN_BIAS     = 9'd127;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // Byte positions within a pixel
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // Queue between decode and output stages
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    // One decoded pixel as it travels from decode to output
    typedef struct packed {
        logic [7:0] byte0;        // stored first byte (blue)
        logic [7:0] byte1;        // stored second byte (green)
        logic [7:0] byte2;        // stored third byte (red)
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       end_of_image;
    } pix_t;

endpackage

// ===== sv/trle_front.sv =====
// Decode front end: configuration registers, packet parsing and pixel assembly.
module trle_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [trle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_data,
    // byte input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      data_byte,
    // push side of the queue
    input  logic                            q_ready,
    output logic                            push,
    output trle_pkg::pix_t                  push_pix
);
    import trle_pkg::*;

    logic                 compressed_reg;
    logic                 four_byte_reg;
    logic [CFG_PIX_W-1:0] image_pixels_reg;

    logic                 awaiting_reg,  awaiting_next;
    logic                 is_run_reg,    is_run_next;
    logic [7:0]           pkt_left_reg,  pkt_left_next;
    logic [1:0]           pos_reg,       pos_next;
    logic [23:0]          coll_reg,      coll_next;
    logic [LEFT_W-1:0]    img_left_reg,  img_left_next;

    logic              accept;
    logic [CMP_W-1:0]  cfg_ext;
    logic [CMP_W-1:0]  limit_ext;
    logic [LEFT_W-1:0] image_size;
    logic [LEFT_W-1:0] left_eff;
    logic [8:0]        hdr_n;
    logic [8:0]        hdr_n_clip;
    logic              e_is_run;
    logic [7:0]        e_pkt_left;
    logic [1:0]        e_pos;
    logic [23:0]       e_coll;
    logic              last_byte;
    logic [7:0]        count_raw;
    logic [7:0]        count;
    logic [LEFT_W-1:0] left_after;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;
    assign accept    = s_tvalid && q_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compressed_reg   <= 1'b1;
            four_byte_reg    <= 1'b1;
            image_pixels_reg <= CFG_PIX_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COMPRESSED:   compressed_reg   <= cfg_data[0];
                REG_FOUR_BYTE:    four_byte_reg    <= cfg_data[0];
                REG_IMAGE_PIXELS: image_pixels_reg <= cfg_data[CFG_PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Image size: zero counts as one, saturate at the pixel count limit
    assign cfg_ext   = CMP_W'(image_pixels_reg);
    assign limit_ext = CMP_W'(1) << PIXEL_COUNT_BITS;
    always_comb begin
        if (image_pixels_reg == '0) begin
            image_size = LEFT_W'(1);
        end else if (cfg_ext > limit_ext) begin
            image_size = LEFT_W'(limit_ext);
        end else begin
            image_size = LEFT_W'(cfg_ext);
        end
    end

    // Per-byte decode
    always_comb begin
        awaiting_next = awaiting_reg;
        is_run_next   = is_run_reg;
        pkt_left_next = pkt_left_reg;
        pos_next      = pos_reg;
        coll_next     = coll_reg;
        img_left_next = img_left_reg;
        push          = 1'b0;
        push_pix      = '0;

        left_eff   = (awaiting_reg && img_left_reg == '0) ? image_size : img_left_reg;
        hdr_n      = (data_byte >= RUN_FLAG_MIN) ? ({1'b0, data_byte} - RUN_BIAS)
                                                 : ({1'b0, data_byte} + 9'd1);
        hdr_n_clip = (LEFT_W'(hdr_n) > left_eff) ? 9'(left_eff) : hdr_n;

        // raw mode opens a one-pixel literal packet without a header byte
        e_is_run   = awaiting_reg ? 1'b0  : is_run_reg;
        e_pkt_left = awaiting_reg ? 8'd1  : pkt_left_reg;
        e_pos      = awaiting_reg ? 2'd0  : pos_reg;
        e_coll     = awaiting_reg ? 24'd0 : coll_reg;

        last_byte = (e_pos == POS_FOURTH) || (e_pos == POS_THIRD && !four_byte_reg);

        count_raw  = e_is_run ? e_pkt_left : 8'd1;
        if (count_raw == 8'd0) begin
            count_raw = 8'd1;
        end
        count      = (LEFT_W'(count_raw) > left_eff) ? 8'(left_eff) : count_raw;
        left_after = left_eff - LEFT_W'(count);

        if (accept) begin
            img_left_next = left_eff;
            if (awaiting_reg && compressed_reg) begin
                // packet header byte
                is_run_next   = (data_byte >= RUN_FLAG_MIN);
                pkt_left_next = hdr_n_clip[7:0];
                awaiting_next = 1'b0;
                pos_next      = 2'd0;
                coll_next     = 24'd0;
            end else if (!last_byte) begin
                // collect a pixel byte
                awaiting_next = 1'b0;
                is_run_next   = e_is_run;
                pkt_left_next = e_pkt_left;
                coll_next     = e_coll;
                case (e_pos)
                    2'd0:    coll_next[7:0]   = data_byte;
                    2'd1:    coll_next[15:8]  = data_byte;
                    2'd2:    coll_next[23:16] = data_byte;
                    default: ;
                endcase
                pos_next = e_pos + 2'd1;
            end else begin
                // pixel complete
                push              = 1'b1;
                push_pix.byte0    = e_coll[7:0];
                push_pix.byte1    = e_coll[15:8];
                push_pix.byte2    = (e_pos == POS_THIRD) ? data_byte : e_coll[23:16];
                push_pix.alpha    = (e_pos == POS_FOURTH) ? data_byte : ALPHA_OPAQUE;
                push_pix.repeat_count = count;
                push_pix.end_of_image = (left_after == '0);

                img_left_next = left_after;
                pos_next      = 2'd0;
                coll_next     = 24'd0;
                is_run_next   = e_is_run;
                if (e_is_run || e_pkt_left <= 8'd1) begin
                    pkt_left_next = 8'd0;
                    awaiting_next = 1'b1;
                end else begin
                    pkt_left_next = e_pkt_left - 8'd1;
                    awaiting_next = 1'b0;
                end
                if (left_after == '0) begin
                    awaiting_next = 1'b1;
                    is_run_next   = 1'b0;
                    pkt_left_next = 8'd0;
                end
            end
        end
    end

    // Decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= 1'b1;
            is_run_reg   <= 1'b0;
            pkt_left_reg <= 8'd0;
            pos_reg      <= 2'd0;
            coll_reg     <= 24'd0;
            img_left_reg <= '0;
        end else begin
            awaiting_reg <= awaiting_next;
            is_run_reg   <= is_run_next;
            pkt_left_reg <= pkt_left_next;
            pos_reg      <= pos_next;
            coll_reg     <= coll_next;
            img_left_reg <= img_left_next;
        end
    end

endmodule

// ===== sv/trle_queue.sv =====
// Short pixel queue between the decode front end and the output stage.
module trle_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  trle_pkg::pix_t push_pix,
    output logic           q_ready,
    input  logic           pop,
    output logic           q_valid,
    output trle_pkg::pix_t q_pix
);
    import trle_pkg::*;

    pix_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;
    logic              do_push;
    logic              do_pop;

    assign q_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_pix   = slot_reg[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_pix;
        end
    end

endmodule

// ===== sv/trle_back.sv =====
// Output stage: byte swap to RGBA order and the registered result stream.
module trle_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  trle_pkg::pix_t                    q_pix,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [trle_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import trle_pkg::*;

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic                  last_reg;

    // take the next item whenever the output register is empty or being drained
    assign pop      = q_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Stored order is B,G,R: red comes from the third byte
    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= {q_pix.repeat_count, q_pix.alpha, q_pix.byte0,
                         q_pix.byte1, q_pix.byte2};
            last_reg <= q_pix.end_of_image;
        end
    end

endmodule

// ===== sv/targa_rle_pixel_decoder_unit.sv =====
// Top level of the Targa pixel-data decoder (raw and run-length packets).
// m_tvalid rises after a pixel passes a queue slot and the output register.
// Throughput: one byte per cycle until a stalled result side fills the 2-entry
// queue plus the output register (3 pixels) and s_tready drops; the decode front
// end updates its packet and pixel state once per byte.
// Reset (aresetn, synchronous, active low): compressed=1, 32-bit pixels,
// image of 1 pixel, waiting for a packet header, queue and output empty.
module targa_rle_pixel_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trle_pkg::CFG_DATA_W-1:0]   cfg_data,
    // byte input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [trle_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    // pixel result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count
    output logic [trle_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast    // end_of_image
);
    import trle_pkg::*;

    logic q_ready;
    logic push;
    pix_t push_pix;
    logic pop;
    logic q_valid;
    pix_t q_pix;

    trle_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .data_byte (s_tdata),
        .q_ready   (q_ready),
        .push      (push),
        .push_pix  (push_pix)
    );

    trle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_pix (push_pix),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_pix    (q_pix)
    );

    trle_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pix    (q_pix),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
